@@ rtl/iou_pkg.sv @@
// shared types, constants and helpers of the io unit completion scheduler
package iou_pkg;

  // unit array size and lba granularity
  localparam int MAX_UNITS  = 8;
  localparam int LBA_SHIFT  = 9;
  localparam int UNIT_IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CNT_W      = $clog2(MAX_UNITS + 1);

  // field widths
  localparam int OP_W      = 2;
  localparam int LBA_W     = 48;
  localparam int LEN_W     = 32;
  localparam int TIME_W    = 64;
  localparam int CFG_W     = 32;
  localparam int SHIFT_W   = 5;
  localparam int UCOUNT_W  = 4;
  localparam int CFG_IDX_W = 4;

  // serial modulo: bits consumed per cycle and number of steps
  localparam int MOD_DIGIT_W = 8;
  localparam int MOD_STEPS   = LBA_W / MOD_DIGIT_W;
  localparam int MOD_STEP_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // command classes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_OTHER = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SHIFT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WR_DELAY   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WR_TIME    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WR_TRAIL   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_RD_DELAY   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_RD_TIME    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_RD_TRAIL   = CFG_IDX_W'(7);

  // configuration register file
  typedef struct packed {
    logic [SHIFT_W-1:0]  unit_shift;
    logic [UCOUNT_W-1:0] unit_count;
    logic [CFG_W-1:0]    wr_delay;
    logic [CFG_W-1:0]    wr_time;
    logic [CFG_W-1:0]    wr_trail;
    logic [CFG_W-1:0]    rd_delay;
    logic [CFG_W-1:0]    rd_time;
    logic [CFG_W-1:0]    rd_trail;
  } cfg_t;

  // one held command
  typedef struct packed {
    op_t                op;
    logic [LBA_W-1:0]   lba;
    logic [LEN_W-1:0]   length;
    logic [TIME_W-1:0]  start_time;
  } cmd_t;

  // core status toward the channel logic
  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_sts_t;

  // number of units in use, clamped to 1..MAX_UNITS
  function automatic logic [CNT_W-1:0] units_in_use(input logic [UCOUNT_W-1:0] count);
    logic [CNT_W-1:0] n;
    if (count == '0) begin
      n = CNT_W'(1);
    end else if (32'(count) > MAX_UNITS) begin
      n = CNT_W'(MAX_UNITS);
    end else begin
      n = CNT_W'(count);
    end
    return n;
  endfunction

endpackage

@@ rtl/iou_mod_unit.sv @@
// serial modulo unit: operand mod a small divisor, one byte of operand per cycle
module iou_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [iou_pkg::LBA_W-1:0]      operand,
  input  logic [iou_pkg::CNT_W-1:0]      divisor,
  output logic                           done,
  output logic [iou_pkg::UNIT_IDX_W-1:0] rem
);

  localparam logic [iou_pkg::MOD_STEP_W-1:0] MOD_ONE = iou_pkg::MOD_STEP_W'(1);

  logic                             busy_r;
  logic [iou_pkg::MOD_STEP_W-1:0]   step_r;
  logic [iou_pkg::LBA_W-1:0]        opnd_r;
  logic [iou_pkg::CNT_W-1:0]        div_r;
  logic [iou_pkg::CNT_W-1:0]        rem_r;
  logic [iou_pkg::CNT_W-1:0]        rem_nxt;

  // eight restoring steps on the top byte of the operand
  always_comb begin
    logic [iou_pkg::CNT_W:0] acc;
    acc = {1'b0, rem_r};
    for (int i = 0; i < iou_pkg::MOD_DIGIT_W; i++) begin
      acc = {acc[iou_pkg::CNT_W-1:0], opnd_r[iou_pkg::LBA_W-1-i]};
      if (acc >= {1'b0, div_r}) begin
        acc = acc - {1'b0, div_r};
      end
    end
    rem_nxt = acc[iou_pkg::CNT_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + MOD_ONE;
      if (step_r == iou_pkg::MOD_STEP_W'(iou_pkg::MOD_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      opnd_r <= operand;
      div_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      opnd_r <= opnd_r << iou_pkg::MOD_DIGIT_W;
      rem_r  <= rem_nxt;
    end
  end

  assign done = !busy_r;
  assign rem  = rem_r[iou_pkg::UNIT_IDX_W-1:0];

endmodule

@@ rtl/iou_core.sv @@
// sequencer, busy-time memory and timing datapath of the scheduler
module iou_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  iou_pkg::cfg_t              cfg,
  input  iou_pkg::cmd_t              cmd,
  input  logic                       start,
  input  logic                       res_ready,
  output iou_pkg::core_sts_t         sts,
  output logic [iou_pkg::TIME_W-1:0] res_time
);

  localparam int IW = iou_pkg::UNIT_IDX_W;
  localparam int CW = iou_pkg::CNT_W;
  localparam int LW = iou_pkg::LEN_W;
  localparam int TW = iou_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MOD, S_RD, S_BASE, S_WALK, S_FLUSH, S_RES
  } state_t;

  state_t                      state_r;
  logic                        need_nz_r;
  logic                        chunks_ge_r;
  logic [LW-1:0]               j_r;
  logic [CW-1:0]               left_r;
  logic [LW-1:0]               mul_a_r;
  logic [iou_pkg::CFG_W-1:0]   delay_r;
  logic [iou_pkg::CFG_W-1:0]   lat_r;
  logic [iou_pkg::CFG_W-1:0]   trail_r;
  logic [TW-1:0]               prod_r;
  logic [TW-1:0]               dp_r;
  logic [TW-1:0]               t_r;
  logic [IW-1:0]               u_r;
  logic [CW-1:0]               idx_r;
  logic                        rd_pend_r;
  logic [TW-1:0]               best_r;
  logic [TW-1:0]               res_time_r;

  // busy-time memory with valid bits standing in for the zero reset
  logic [TW-1:0]               mem [iou_pkg::MAX_UNITS];
  logic [iou_pkg::MAX_UNITS-1:0] vld_r;
  logic [TW-1:0]               rd_data_r;
  logic                        rd_ok_r;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic                        wr_en;
  logic [TW-1:0]               wr_data;
  logic [TW-1:0]               rd_val;

  logic [CW-1:0]               cnt;
  logic [iou_pkg::SHIFT_W-1:0] sh;
  logic [iou_pkg::LBA_W-1:0]   lba_sh;
  logic [LW-1:0]               len_mask;
  logic [LW-1:0]               need;
  logic [LW-1:0]               chunks;
  logic                        chunks_ge;
  logic [CW-1:0]               m;
  logic [LW-1:0]               j0;
  logic [iou_pkg::CFG_W-1:0]   sel_delay;
  logic [iou_pkg::CFG_W-1:0]   sel_lat;
  logic [iou_pkg::CFG_W-1:0]   sel_trail;
  logic                        mod_start;
  logic                        first_done;
  logic                        crem_done;
  logic [IW-1:0]               first;
  logic [IW-1:0]               crem;
  logic [CW:0]                 usum;
  logic [IW-1:0]               u0;
  logic [IW-1:0]               u_inc;
  logic                        trail_on;
  logic [TW-1:0]               base_max;

  // command decode
  always_comb begin
    cnt       = iou_pkg::units_in_use(cfg.unit_count);
    sh        = (cfg.unit_shift >= iou_pkg::SHIFT_W'(iou_pkg::LBA_SHIFT)) ?
                cfg.unit_shift - iou_pkg::SHIFT_W'(iou_pkg::LBA_SHIFT) : '0;
    lba_sh    = cmd.lba >> sh;
    len_mask  = ~({LW{1'b1}} << cfg.unit_shift);
    need      = (cmd.length >> cfg.unit_shift) + LW'(|(cmd.length & len_mask));
    chunks    = (need == '0) ? LW'(1) : need;
    chunks_ge = (chunks >= LW'(cnt));
    m         = chunks_ge ? cnt : CW'(chunks);
    j0        = chunks - LW'(m);
  end

  // per-class timing selection
  always_comb begin
    case (cmd.op)
      iou_pkg::OP_WRITE: begin
        sel_delay = cfg.wr_delay;
        sel_lat   = cfg.wr_time;
        sel_trail = cfg.wr_trail;
      end
      iou_pkg::OP_READ: begin
        sel_delay = cfg.rd_delay;
        sel_lat   = cfg.rd_time;
        sel_trail = cfg.rd_trail;
      end
      default: begin
        sel_delay = '0;
        sel_lat   = '0;
        sel_trail = '0;
      end
    endcase
  end

  // first unit and chunk count modulo the units in use
  assign mod_start = (state_r == S_PREP);

  iou_mod_unit u_first_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .operand (lba_sh),
    .divisor (cnt),
    .done    (first_done),
    .rem     (first)
  );

  iou_mod_unit u_chunk_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .operand (iou_pkg::LBA_W'(chunks)),
    .divisor (cnt),
    .done    (crem_done),
    .rem     (crem)
  );

  // unit of the first chunk that is kept, and round-robin step
  always_comb begin
    usum  = (CW+1)'(first) + (CW+1)'(crem);
    if (!chunks_ge_r) begin
      u0 = first;
    end else if (usum >= (CW+1)'(cnt)) begin
      u0 = IW'(usum - (CW+1)'(cnt));
    end else begin
      u0 = IW'(usum);
    end
    u_inc = (u_r == IW'(cnt - CW'(1))) ? '0 : u_r + IW'(1);
  end

  // memory access control
  always_comb begin
    rd_val   = rd_ok_r ? rd_data_r : '0;
    rd_en    = (state_r == S_RD) || ((state_r == S_FLUSH) && (idx_r < cnt));
    rd_addr  = (state_r == S_RD) ? first : idx_r[IW-1:0];
    wr_en    = (state_r == S_WALK);
    trail_on = need_nz_r && (j_r < LW'(cnt));
    wr_data  = t_r + (trail_on ? TW'(trail_r) : '0);
    base_max = (cmd.start_time > rd_val) ? cmd.start_time : rd_val;
  end

  // memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[u_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[u_r] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= vld_r[rd_addr];
      end
    end
  end

  // sequencer and timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (cmd.op == iou_pkg::OP_FLUSH) begin
              idx_r     <= '0;
              rd_pend_r <= 1'b0;
              best_r    <= '0;
              state_r   <= S_FLUSH;
            end else begin
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          need_nz_r   <= (need != '0);
          chunks_ge_r <= chunks_ge;
          j_r         <= j0;
          left_r      <= m;
          mul_a_r     <= j0 + LW'(1);
          delay_r     <= sel_delay;
          lat_r       <= sel_lat;
          trail_r     <= sel_trail;
          state_r     <= S_MOD;
        end
        S_MOD: begin
          prod_r <= TW'(mul_a_r) * TW'(lat_r);
          if (first_done && crem_done) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          dp_r    <= TW'(delay_r) + prod_r;
          u_r     <= u0;
          state_r <= S_BASE;
        end
        S_BASE: begin
          t_r     <= base_max + dp_r;
          state_r <= S_WALK;
        end
        S_WALK: begin
          t_r    <= t_r + TW'(lat_r);
          j_r    <= j_r + LW'(1);
          u_r    <= u_inc;
          left_r <= left_r - CW'(1);
          if (left_r == CW'(1)) begin
            res_time_r <= t_r;
            state_r    <= S_RES;
          end
        end
        S_FLUSH: begin
          rd_pend_r <= rd_en;
          if (rd_en) begin
            idx_r <= idx_r + CW'(1);
          end
          if (rd_pend_r && (rd_val > best_r)) begin
            best_r <= rd_val;
          end
          if ((idx_r == cnt) && !rd_pend_r) begin
            res_time_r <= best_r;
            state_r    <= S_RES;
          end
        end
        S_RES: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign sts.idle      = (state_r == S_IDLE);
  assign sts.res_valid = (state_r == S_RES);
  assign res_time      = res_time_r;

endmodule

@@ rtl/io_unit_completion_scheduler_unit.sv @@
// top level of the io unit completion scheduler: channels, config registers, output register
//
// Keeps a busy-until time for each of up to MAX_UNITS io units and returns one
// completion time per command transaction (or the latest busy time for a flush).
// Channels: in_* carries op, lba, length and start_time with valid/ready;
// out_* carries done_time with valid/ready; cfg_* writes one configuration
// register per transaction (index in cfg_addr, data in cfg_wdata), always ready.
// Path of a timing command: the held command starts the core, which waits on the
// byte-serial modulo that finds the first unit, then rewrites the busy time of each
// unit concerned (1 to units in use) through the single write port of the busy-time
// memory before out_valid rises. A flush makes one memory read per unit in use.
// One command is in flight at a time; the next transaction can be taken in the cycle
// after the previous result has moved to the output register. A stalled receiver
// holds at most one result plus one command.
// Reset (rst_n low, synchronous) clears all busy times to zero, loads the register
// reset values (unit_shift 12, unit_count 8, all delays and times zero) and empties
// both channels. The user must write configuration only while no command is in
// flight; the block itself does not enforce it.
module io_unit_completion_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iou_pkg::OP_W-1:0]      in_op,
  input  logic [iou_pkg::LBA_W-1:0]     in_lba,
  input  logic [iou_pkg::LEN_W-1:0]     in_length,
  input  logic [iou_pkg::TIME_W-1:0]    in_start_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iou_pkg::TIME_W-1:0]    out_done_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [iou_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [iou_pkg::CFG_W-1:0]     cfg_wdata
);

  iou_pkg::cfg_t               cfg_r;
  iou_pkg::cmd_t               cmd_r;
  logic                        cmd_valid_r;
  logic                        out_valid_r;
  logic [iou_pkg::TIME_W-1:0]  out_time_r;
  iou_pkg::core_sts_t          sts;
  logic [iou_pkg::TIME_W-1:0]  res_time;
  logic                        core_start;
  logic                        res_ready;
  logic                        res_take;
  logic                        in_take;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !cmd_valid_r;
  assign in_take    = in_valid && in_ready;
  assign core_start = cmd_valid_r && sts.idle;
  assign res_ready  = !out_valid_r || out_ready;
  assign res_take   = sts.res_valid && res_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_shift <= iou_pkg::SHIFT_W'(12);
      cfg_r.unit_count <= iou_pkg::UCOUNT_W'(8);
      cfg_r.wr_delay   <= '0;
      cfg_r.wr_time    <= '0;
      cfg_r.wr_trail   <= '0;
      cfg_r.rd_delay   <= '0;
      cfg_r.rd_time    <= '0;
      cfg_r.rd_trail   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        iou_pkg::CFG_UNIT_SHIFT: cfg_r.unit_shift <= cfg_wdata[iou_pkg::SHIFT_W-1:0];
        iou_pkg::CFG_UNIT_COUNT: cfg_r.unit_count <= cfg_wdata[iou_pkg::UCOUNT_W-1:0];
        iou_pkg::CFG_WR_DELAY:   cfg_r.wr_delay   <= cfg_wdata;
        iou_pkg::CFG_WR_TIME:    cfg_r.wr_time    <= cfg_wdata;
        iou_pkg::CFG_WR_TRAIL:   cfg_r.wr_trail   <= cfg_wdata;
        iou_pkg::CFG_RD_DELAY:   cfg_r.rd_delay   <= cfg_wdata;
        iou_pkg::CFG_RD_TIME:    cfg_r.rd_time    <= cfg_wdata;
        iou_pkg::CFG_RD_TRAIL:   cfg_r.rd_trail   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // command holding register, freed when its result moves out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (in_take) begin
      cmd_valid_r <= 1'b1;
    end else if (res_take) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r.op         <= iou_pkg::op_t'(in_op);
      cmd_r.lba        <= in_lba;
      cmd_r.length     <= in_length;
      cmd_r.start_time <= in_start_time;
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_time_r <= res_time;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_done_time = out_time_r;

  iou_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd_r),
    .start     (core_start),
    .res_ready (res_ready),
    .sts       (sts),
    .res_time  (res_time)
  );

  // a result only exists for a held command
  a_res_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    sts.res_valid |-> cmd_valid_r)
    else $error("core result without a held command");

  // the core leaves idle right after being started
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    core_start |=> !sts.idle)
    else $error("core stayed idle after start");

  // a handed-off result lands in the output register and frees the command slot
  a_res_moves: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_valid_r && !cmd_valid_r))
    else $error("result hand-off lost");

  // a stalled output register never takes a new result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !res_take)
    else $error("output register overwritten while stalled");

endmodule

@@ verif/io_unit_completion_scheduler_unit_tb.sv @@
// testbench of the io unit completion scheduler: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module io_unit_completion_scheduler_unit_tb;
  import iou_pkg::*;

  // one step of the directed plan: a command or a register write
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_data;
    op_t                  op;
    logic [LBA_W-1:0]     lba;
    logic [LEN_W-1:0]     length;
    logic [TIME_W-1:0]    start_time;
    bit                   known;
    logic [TIME_W-1:0]    known_time;
  } plan_row_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_RD_TRAIL + CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     ALL_ONES32 = '1;
  localparam logic [TIME_W-1:0]    ALL_ONES64 = '1;
  localparam logic [LBA_W-1:0]     LBA_MAX    = '1;
  localparam int                   PHASES     = 6;
  localparam int                   PHASE_CMDS = 125;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      in_op;
  logic [LBA_W-1:0]     in_lba;
  logic [LEN_W-1:0]     in_length;
  logic [TIME_W-1:0]    in_start_time;
  logic                 out_valid;
  logic                 out_ready;
  logic [TIME_W-1:0]    out_done_time;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  // predictor state: register copy and per-unit busy times
  cfg_t              model_cfg;
  logic [TIME_W-1:0] unit_busy [MAX_UNITS];

  logic [TIME_W-1:0] done_time_q[$];
  plan_row_t         plan_q[$];
  int                timing_errors;
  bit                quiet_run;
  logic [TIME_W-1:0] now_ns;

  io_unit_completion_scheduler_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_lba        (in_lba),
    .in_length     (in_length),
    .in_start_time (in_start_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_done_time (out_done_time),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // register write into the predictor copy
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_UNIT_SHIFT: model_cfg.unit_shift = data[SHIFT_W-1:0];
      CFG_UNIT_COUNT: model_cfg.unit_count = data[UCOUNT_W-1:0];
      CFG_WR_DELAY:   model_cfg.wr_delay   = data;
      CFG_WR_TIME:    model_cfg.wr_time    = data;
      CFG_WR_TRAIL:   model_cfg.wr_trail   = data;
      CFG_RD_DELAY:   model_cfg.rd_delay   = data;
      CFG_RD_TIME:    model_cfg.rd_time    = data;
      CFG_RD_TRAIL:   model_cfg.rd_trail   = data;
      default: ;
    endcase
  endfunction

  // completion time of one command; updates the busy times
  function automatic logic [TIME_W-1:0] sched_done_time(op_t op, logic [LBA_W-1:0] lba,
                                                        logic [LEN_W-1:0] len,
                                                        logic [TIME_W-1:0] start);
    logic [63:0] cnt, delay, lat, trail, size, shamt, first_unit;
    logic [63:0] need, chunks, ntrail, base, j, t, k, result;
    if (model_cfg.unit_count == 0) begin
      cnt = 1;
    end else if (model_cfg.unit_count > MAX_UNITS) begin
      cnt = MAX_UNITS;
    end else begin
      cnt = 64'(model_cfg.unit_count);
    end
    delay = 0;
    lat   = 0;
    trail = 0;
    result = 0;
    if (op == OP_FLUSH) begin
      // latest busy time over the units in use only
      for (k = 0; k < cnt; k++) begin
        if (unit_busy[k] > result) result = unit_busy[k];
      end
    end else begin
      if (op == OP_WRITE) begin
        delay = 64'(model_cfg.wr_delay);
        lat   = 64'(model_cfg.wr_time);
        trail = 64'(model_cfg.wr_trail);
      end else if (op == OP_READ) begin
        delay = 64'(model_cfg.rd_delay);
        lat   = 64'(model_cfg.rd_time);
        trail = 64'(model_cfg.rd_trail);
      end
      size       = 64'd1 << model_cfg.unit_shift;
      shamt      = (model_cfg.unit_shift >= LBA_SHIFT) ? 64'(model_cfg.unit_shift - LBA_SHIFT) : 0;
      first_unit = (64'(lba) >> shamt) % cnt;
      need       = (64'(len) + size - 1) / size;
      chunks     = (need == 0) ? 64'd1 : need;
      ntrail     = (need < cnt) ? need : cnt;
      base = unit_busy[first_unit];
      if (start > base) base = start;
      base = base + delay;
      // each unit keeps the time of the last chunk it receives
      for (k = 0; k < cnt && k < chunks; k++) begin
        j = k + cnt * ((chunks - 1 - k) / cnt);
        t = base + (j + 1) * lat;
        if (j < ntrail) t = t + trail;
        unit_busy[(first_unit + k) % cnt] = t;
      end
      result = base + chunks * lat;
    end
    return result;
  endfunction

  // directed plan builders
  function automatic void plan_cmd(op_t op, logic [LBA_W-1:0] lba, logic [LEN_W-1:0] len,
                                   logic [TIME_W-1:0] start, bit known = 1'b0,
                                   logic [TIME_W-1:0] known_time = '0);
    plan_row_t row;
    row = '{op: OP_WRITE, default: '0};
    row.op         = op;
    row.lba        = lba;
    row.length     = len;
    row.start_time = start;
    row.known      = known;
    row.known_time = known_time;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '{op: OP_WRITE, default: '0};
    row.is_reg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    plan_q.push_back(row);
  endfunction

  // one command transaction; cfg_valid stays as it is
  task automatic send_cmd(op_t op, logic [LBA_W-1:0] lba, logic [LEN_W-1:0] len,
                          logic [TIME_W-1:0] start, bit known, logic [TIME_W-1:0] known_time);
    logic [TIME_W-1:0] predicted;
    while (!quiet_run && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_lba        <= lba;
    in_length     <= len;
    in_start_time <= start;
    do @(posedge clk); while (!in_ready);
    predicted = sched_done_time(op, lba, len, start);
    done_time_q.push_back(known ? known_time : predicted);
  endtask

  // one register write transaction; cfg_valid is left high
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // wait until the block is idle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (done_time_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_timing();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES32;
    if (r == 2) return $urandom;
    return $urandom_range(0, 5000);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    logic [63:0] size, len64;
    int unsigned r;
    size = 64'd1 << model_cfg.unit_shift;
    r = $urandom_range(99);
    if (r < 8) begin
      len64 = 0;
    end else if (r < 18) begin
      len64 = 64'($urandom);
    end else if (r < 22) begin
      len64 = 64'(ALL_ONES32);
    end else begin
      len64 = 64'($urandom_range(0, 11)) * size + (64'($urandom) & (size - 1));
      // exact multiples of the unit size now and then
      if (r < 40) len64 = len64 & ~(size - 1);
      if (len64 > 64'(ALL_ONES32)) len64 = 64'($urandom);
    end
    return len64[LEN_W-1:0];
  endfunction

  // receiver stall
  always @(posedge clk) begin
    out_ready <= quiet_run || ($urandom_range(99) >= 11);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (done_time_q.size() == 0) begin
        $display("%0t: unexpected done_time transaction, expected none, actual %h",
                 $time, out_done_time);
        timing_errors++;
      end else if (done_time_q[0] !== out_done_time) begin
        $display("%0t: done_time mismatch, expected %h, actual %h",
                 $time, done_time_q[0], out_done_time);
        timing_errors++;
        void'(done_time_q.pop_front());
      end else begin
        void'(done_time_q.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    logic [TIME_W-1:0] start;
    logic [LBA_W-1:0]  lba;
    op_t               op;
    int unsigned       r;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_WRITE;
    in_lba        <= '0;
    in_length     <= '0;
    in_start_time <= '0;
    cfg_valid     <= 1'b0;
    cfg_addr      <= CFG_UNIT_SHIFT;
    cfg_wdata     <= '0;
    out_ready     <= 1'b0;
    timing_errors = 0;
    quiet_run     = 1'b0;
    now_ns        = 0;

    // reset values of the predictor
    model_cfg = '0;
    model_cfg.unit_shift = SHIFT_W'(12);
    model_cfg.unit_count = UCOUNT_W'(8);
    for (int u = 0; u < MAX_UNITS; u++) unit_busy[u] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: reset state first, then extreme settings
    plan_cmd(OP_FLUSH, '0, '0, '0, 1'b1, '0);
    plan_cmd(OP_WRITE, '0, '0, 64'd1000, 1'b1, 64'd1000);
    plan_cmd(OP_FLUSH, '0, '0, '0, 1'b1, 64'd1000);
    plan_cmd(OP_READ, 48'd8, 32'd4096, 64'd500, 1'b1, 64'd500);
    plan_cmd(OP_OTHER, LBA_MAX, '0, ALL_ONES64, 1'b1, ALL_ONES64);
    plan_cmd(OP_FLUSH, '0, '0, '0, 1'b1, ALL_ONES64);
    // unit count zero acts as one unit, times wrap
    plan_reg(CFG_UNIT_COUNT, '0);
    plan_reg(CFG_WR_DELAY, ALL_ONES32);
    plan_reg(CFG_WR_TIME, 32'd1);
    plan_reg(CFG_WR_TRAIL, ALL_ONES32);
    plan_reg(CFG_RD_DELAY, '0);
    plan_reg(CFG_RD_TIME, ALL_ONES32);
    plan_reg(CFG_RD_TRAIL, '0);
    plan_reg(CFG_UNIT_SHIFT, 32'd9);
    plan_cmd(OP_WRITE, 48'd3, 32'd1, '0);
    plan_cmd(OP_FLUSH, '0, '0, '0);
    plan_cmd(OP_READ, LBA_MAX, ALL_ONES32, '0);
    // count above the array size, unit shift below the lba shift
    plan_reg(CFG_UNIT_COUNT, 32'd15);
    plan_reg(CFG_UNIT_SHIFT, 32'd0);
    plan_cmd(OP_READ, 48'd5, 32'd20, 64'd12345);
    plan_cmd(OP_WRITE, 48'h8000_0000_0000, 32'd3, 64'h8000_0000_0000_0000);
    plan_cmd(OP_OTHER, 48'd7, ALL_ONES32, 64'd1);
    plan_reg(CFG_UNIT_SHIFT, 32'd31);
    plan_cmd(OP_WRITE, 48'h1234_5678_9abc, ALL_ONES32, 64'd2000);
    // lowered count hides the upper units until it grows again
    plan_reg(CFG_UNIT_COUNT, 32'd3);
    plan_cmd(OP_OTHER, 48'd2, '0, 64'd3000);
    plan_cmd(OP_FLUSH, '0, '0, '0);
    plan_reg(CFG_UNIT_COUNT, 32'd8);
    plan_cmd(OP_FLUSH, '0, '0, '0);
    // write to an unused index is dropped
    plan_reg(CFG_UNUSED, ALL_ONES32);
    plan_reg(CFG_UNIT_SHIFT, 32'd24);
    plan_reg(CFG_UNIT_COUNT, 32'd5);
    plan_reg(CFG_WR_TRAIL, 32'd7);
    plan_cmd(OP_READ, 48'h0000_0800_0000, 32'd7 << 24, 64'd5000);
    plan_cmd(OP_WRITE, '0, (32'd1 << 24) + 32'd1, '0);
    plan_cmd(OP_FLUSH, '0, '0, '0);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_reg) begin
        if (i == 0 || !plan_q[i-1].is_reg) drain();
        reg_write(plan_q[i].reg_idx, plan_q[i].reg_data);
        if (i == plan_q.size() - 1 || !plan_q[i+1].is_reg) cfg_valid <= 1'b0;
      end else begin
        send_cmd(plan_q[i].op, plan_q[i].lba, plan_q[i].length, plan_q[i].start_time,
                 plan_q[i].known, plan_q[i].known_time);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        // low extreme
        reg_write(CFG_UNIT_SHIFT, 32'd9);
        reg_write(CFG_UNIT_COUNT, 32'd1);
        reg_write(CFG_WR_DELAY, '0);
        reg_write(CFG_WR_TIME, '0);
        reg_write(CFG_WR_TRAIL, '0);
        reg_write(CFG_RD_DELAY, '0);
        reg_write(CFG_RD_TIME, '0);
        reg_write(CFG_RD_TRAIL, '0);
      end else if (ph == PHASES - 1) begin
        // high extreme
        reg_write(CFG_UNIT_SHIFT, 32'd24);
        reg_write(CFG_UNIT_COUNT, 32'd8);
        reg_write(CFG_WR_DELAY, ALL_ONES32);
        reg_write(CFG_WR_TIME, ALL_ONES32);
        reg_write(CFG_WR_TRAIL, ALL_ONES32);
        reg_write(CFG_RD_DELAY, ALL_ONES32);
        reg_write(CFG_RD_TIME, ALL_ONES32);
        reg_write(CFG_RD_TRAIL, ALL_ONES32);
      end else begin
        // upper data bits of the narrow registers carry junk
        if ($urandom_range(3) == 0) begin
          reg_write(CFG_UNIT_SHIFT, ($urandom & ~32'h1f) | 32'($urandom_range(0, 31)));
        end else begin
          reg_write(CFG_UNIT_SHIFT, ($urandom & ~32'h1f) | 32'($urandom_range(9, 24)));
        end
        reg_write(CFG_UNIT_COUNT, ($urandom & ~32'hf) | 32'($urandom_range(0, 15)));
        reg_write(CFG_WR_DELAY, pick_timing());
        reg_write(CFG_WR_TIME, pick_timing());
        reg_write(CFG_WR_TRAIL, pick_timing());
        reg_write(CFG_RD_DELAY, pick_timing());
        reg_write(CFG_RD_TIME, pick_timing());
        reg_write(CFG_RD_TRAIL, pick_timing());
        reg_write(CFG_UNUSED + CFG_IDX_W'($urandom_range(0, 7)), $urandom);
      end
      cfg_valid <= 1'b0;
      quiet_run = (ph == 3);

      for (int n = 0; n < PHASE_CMDS; n++) begin
        r = $urandom_range(99);
        if (r < 35) begin
          op = OP_WRITE;
        end else if (r < 70) begin
          op = OP_READ;
        end else if (r < 85) begin
          op = OP_OTHER;
        end else begin
          op = OP_FLUSH;
        end
        lba = ($urandom_range(3) == 0) ? LBA_W'($urandom_range(0, 64))
                                        : LBA_W'({$urandom, $urandom});
        // mostly a rising device clock, sometimes a stale or arbitrary start
        now_ns = now_ns + 64'($urandom_range(0, 4000));
        r = $urandom_range(99);
        if (r < 8) begin
          start = {$urandom, $urandom};
        end else if (r < 14) begin
          start = now_ns - 64'($urandom_range(0, 20000));
        end else begin
          start = now_ns;
        end
        send_cmd(op, lba, pick_length(), start, 1'b0, '0);
      end
      quiet_run = 1'b0;
    end

    // wait out the last results
    in_valid <= 1'b0;
    while (done_time_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (timing_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
